[hdl/price_level_order_book_defines.svh]
// Assertion macros for the price-level order book.
// Used by the top level only; no other dependencies.
`ifndef PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH
`define PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH

// clocked check, off while reset is high
`define PLOB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define PLOB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/plob_pkg.sv]
// Shared types and constants of the price-level order book.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package plob_pkg;
   typedef enum logic [2:0] {OP_HOLD, OP_CMP, OP_SET, OP_DEL, OP_INS, OP_CLR} plob_op_type;

   localparam logic [1:0] REQ_UPDATE   = 2'd0;
   localparam logic [1:0] REQ_SNAPSHOT = 2'd1;
   localparam logic [1:0] REQ_CLEAR    = 2'd2;

   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   localparam int          VOL_BITS = 31;
   localparam logic [30:0] VOL_MAX  = 31'h7FFF_FFFF;

   typedef struct packed {
      logic hit;
      logic full;
      logic empty;
   } plob_stat_type;
endpackage
`default_nettype wire

[hdl/plob_chan_if.sv]
// Request and response channel interfaces of the price-level order book.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface plob_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic               side;
   logic [31:0]        price_ticks;
   logic signed [31:0] volume_delta;
   logic [4:0]         snapshot_levels;
   modport source (output valid, req_type, side, price_ticks, volume_delta, snapshot_levels,
                   input ready);
   modport sink   (input valid, req_type, side, price_ticks, volume_delta, snapshot_levels,
                   output ready);
endinterface

interface plob_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] best_bid_price;
   logic [30:0] best_bid_volume;
   logic [31:0] best_ask_price;
   logic [30:0] best_ask_volume;
   logic [32:0] mid_half_ticks;
   logic [31:0] level_price;
   logic [30:0] level_volume;
   logic        level_valid;
   logic        last;
   modport source (output valid, status, best_bid_price, best_bid_volume, best_ask_price,
                   best_ask_volume, mid_half_ticks, level_price, level_volume, level_valid,
                   last, input ready);
   modport sink   (input valid, status, best_bid_price, best_bid_volume, best_ask_price,
                   best_ask_volume, mid_half_ticks, level_price, level_volume, level_valid,
                   last, output ready);
endinterface
`default_nettype wire

[hdl/plob_cell.sv]
// One price level of a side: compare, set, shift in from a neighbour.
// Depends on plob_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plob_cell import plob_pkg::*; #(
   parameter int PRICE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire plob_op_type           op,
   input  wire logic                  side,
   input  wire logic [PRICE_BITS-1:0] price_new,
   input  wire logic [30:0]           vol_new,
   input  wire logic                  occ,
   input  wire logic                  c_prev,
   input  wire logic [PRICE_BITS-1:0] left_price,
   input  wire logic [30:0]           left_vol,
   input  wire logic [PRICE_BITS-1:0] right_price,
   input  wire logic [30:0]           right_vol,
   output      logic [PRICE_BITS-1:0] price,
   output      logic [30:0]           vol,
   output      logic                  c,
   output      logic                  m,
   output      logic                  bnd
);
   logic [PRICE_BITS-1:0] price_ff, price_in;
   logic [30:0]           vol_ff, vol_in;
   logic                  c_ff, c_in, m_ff, m_in;
   logic                  eq, ahead;

   always_comb begin
      bnd      = c_ff & ~c_prev;
      eq       = (price_new == price_ff);
      ahead    = side ? (price_new < price_ff) : (price_new > price_ff);
      price_in = price_ff;
      vol_in   = vol_ff;
      c_in     = c_ff;
      m_in     = m_ff;
      case (op)
         OP_CMP: begin
            c_in = ~occ | eq | ahead;
            m_in = occ & eq;
         end
         OP_SET: begin
            if (bnd) vol_in = vol_new;
         end
         OP_DEL: begin
            if (c_ff) begin
               price_in = right_price;
               vol_in   = right_vol;
            end
         end
         OP_INS: begin
            if (c_prev) begin
               price_in = left_price;
               vol_in   = left_vol;
            end else if (bnd) begin
               price_in = price_new;
               vol_in   = vol_new;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      vol_ff   <= vol_in;
      c_ff     <= c_in;
      m_ff     <= m_in;
   end

   assign price = price_ff;
   assign vol   = vol_ff;
   assign c     = c_ff;
   assign m     = m_ff;
endmodule
`default_nettype wire

[hdl/plob_side.sv]
// One side of the book: a row of level cells kept in rank order, plus its level count.
// Depends on plob_pkg and plob_cell.
`timescale 1ns / 1ps
`default_nettype none
module plob_side import plob_pkg::*; #(
   parameter int LEVELS_PER_SIDE = 64,
   parameter int PRICE_BITS      = 32,
   parameter int SNAP_D          = 16,
   localparam int CW             = $clog2(LEVELS_PER_SIDE + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire plob_op_type           op,
   input  wire logic                  side,
   input  wire logic [PRICE_BITS-1:0] price_new,
   input  wire logic [30:0]           vol_new,
   output      logic [CW-1:0]         count,
   output      plob_stat_type         stat,
   output      logic [30:0]           hit_vol,
   output      logic [PRICE_BITS-1:0] tap_price [SNAP_D],
   output      logic [30:0]           tap_vol [SNAP_D]
);
   logic [CW-1:0]         count_ff, count_in;
   logic [PRICE_BITS-1:0] cp [LEVELS_PER_SIDE];
   logic [30:0]           cv [LEVELS_PER_SIDE];
   logic                  cc [LEVELS_PER_SIDE];
   logic                  cm [LEVELS_PER_SIDE];
   logic                  cb [LEVELS_PER_SIDE];

   for (genvar i = 0; i < LEVELS_PER_SIDE; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      logic [PRICE_BITS-1:0] lp, rp;
      logic [30:0]           lv, rv;
      logic                  cpv;
      if (i == 0) begin : g_first
         assign lp  = '0;
         assign lv  = '0;
         assign cpv = 1'b0;
      end else begin : g_mid
         assign lp  = cp[i-1];
         assign lv  = cv[i-1];
         assign cpv = cc[i-1];
      end
      if (i == LEVELS_PER_SIDE - 1) begin : g_last
         assign rp = '0;
         assign rv = '0;
      end else begin : g_inner
         assign rp = cp[i+1];
         assign rv = cv[i+1];
      end
      plob_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
         .clock(clock), .op(op), .side(side), .price_new(price_new), .vol_new(vol_new),
         .occ(IDX < count_ff), .c_prev(cpv),
         .left_price(lp), .left_vol(lv), .right_price(rp), .right_vol(rv),
         .price(cp[i]), .vol(cv[i]), .c(cc[i]), .m(cm[i]), .bnd(cb[i])
      );
   end

   for (genvar k = 0; k < SNAP_D; k++) begin : g_tap
      assign tap_price[k] = cp[k];
      assign tap_vol[k]   = cv[k];
   end

   always_comb begin
      stat.hit = 1'b0;
      hit_vol  = '0;
      for (int i = 0; i < LEVELS_PER_SIDE; i++) begin
         stat.hit = stat.hit | (cb[i] & cm[i]);
         hit_vol  = hit_vol | (cb[i] ? cv[i] : 31'd0);
      end
      stat.full  = (count_ff == CW'(LEVELS_PER_SIDE));
      stat.empty = (count_ff == '0);
      case (op)
         OP_INS:  count_in = count_ff + 1'b1;
         OP_DEL:  count_in = count_ff - 1'b1;
         OP_CLR:  count_in = '0;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   assign count = count_ff;
endmodule
`default_nettype wire

[hdl/price_level_order_book.sv]
// Price-level order book. Update: compare in every cell, decide from the matching cell,
// apply the shift in one step, register the result (waiting while the output slot is full).
// Snapshot: load the top levels, then one level per cycle while the output slot is free.
// Clear: both rows are emptied on acceptance. One transaction at a time: input reopens
// the cycle after its last result is registered; that result may wait while the next is taken.
// Synchronous reset empties both sides; level contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "price_level_order_book_defines.svh"
module price_level_order_book import plob_pkg::*; #(
   parameter int LEVELS_PER_SIDE = 64,
   parameter int MAX_SNAPSHOT    = 16,
   parameter int PRICE_BITS      = 32
) (
   input wire logic    clock,
   input wire logic    reset,
   plob_req_if.sink    req_chan,
   plob_rsp_if.source  rsp_chan
);
   // only the top cells that a snapshot can ever reach are tapped
   localparam int SNAP_D = (MAX_SNAPSHOT < LEVELS_PER_SIDE) ? MAX_SNAPSHOT : LEVELS_PER_SIDE;
   localparam int CW     = $clog2(LEVELS_PER_SIDE + 1);
   localparam int RW     = $clog2(SNAP_D + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CMP, ST_DEC, ST_APPLY, ST_SNAP_LD, ST_SNAP, ST_RESP
   } state_type;

   state_type             state_ff;
   logic                  side_ff;
   logic [PRICE_BITS-1:0] price_ff;
   logic signed [31:0]    delta_ff;
   logic [4:0]            want_ff;
   plob_op_type           act_ff;
   logic [30:0]           newvol_ff;
   logic                  status_ff;
   logic [PRICE_BITS-1:0] sp_ff [SNAP_D];
   logic [30:0]           sv_ff [SNAP_D];
   logic [RW-1:0]         rem_ff;

   // response register
   logic        rsp_valid_ff, rsp_status_ff, rsp_lvalid_ff, rsp_last_ff;
   logic [31:0] rsp_bbp_ff, rsp_bap_ff, rsp_lp_ff;
   logic [30:0] rsp_bbv_ff, rsp_bav_ff, rsp_lv_ff;
   logic [32:0] rsp_mid_ff;

   // sides
   plob_op_type           bid_op, ask_op;
   logic [CW-1:0]         bid_count, ask_count;
   plob_stat_type         bid_stat, ask_stat, sel_stat;
   logic [30:0]           bid_hvol, ask_hvol, sel_hvol;
   logic [PRICE_BITS-1:0] bid_tp [SNAP_D];
   logic [PRICE_BITS-1:0] ask_tp [SNAP_D];
   logic [30:0]           bid_tv [SNAP_D];
   logic [30:0]           ask_tv [SNAP_D];

   logic        accept, slot_free, rsp_load;
   logic [63:0] req_price64, bp64, ap64, mid64, lp64;
   logic signed [32:0] sum;
   logic [CW-1:0]      sel_count;
   int                 n_snap;

   assign accept    = req_chan.valid & req_chan.ready;
   assign slot_free = ~rsp_valid_ff | rsp_chan.ready;
   // a result is loaded whenever an emitting state finds the output slot free
   assign rsp_load  = slot_free & ((state_ff == ST_SNAP) | (state_ff == ST_RESP));
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_price64    = 64'(req_chan.price_ticks);

   // broadcast commands: clear hits both rows, other work only the addressed side
   always_comb begin
      bid_op = OP_HOLD;
      ask_op = OP_HOLD;
      if (accept && req_chan.req_type == REQ_CLEAR) begin
         bid_op = OP_CLR;
         ask_op = OP_CLR;
      end else if (state_ff == ST_CMP) begin
         if (side_ff == SIDE_ASK) ask_op = OP_CMP;
         else                     bid_op = OP_CMP;
      end else if (state_ff == ST_APPLY) begin
         if (side_ff == SIDE_ASK) ask_op = act_ff;
         else                     bid_op = act_ff;
      end
   end

   plob_side #(.LEVELS_PER_SIDE(LEVELS_PER_SIDE), .PRICE_BITS(PRICE_BITS), .SNAP_D(SNAP_D))
   u_bid (
      .clock(clock), .reset(reset), .op(bid_op), .side(SIDE_BID), .price_new(price_ff),
      .vol_new(newvol_ff), .count(bid_count), .stat(bid_stat), .hit_vol(bid_hvol),
      .tap_price(bid_tp), .tap_vol(bid_tv)
   );

   plob_side #(.LEVELS_PER_SIDE(LEVELS_PER_SIDE), .PRICE_BITS(PRICE_BITS), .SNAP_D(SNAP_D))
   u_ask (
      .clock(clock), .reset(reset), .op(ask_op), .side(SIDE_ASK), .price_new(price_ff),
      .vol_new(newvol_ff), .count(ask_count), .stat(ask_stat), .hit_vol(ask_hvol),
      .tap_price(ask_tp), .tap_vol(ask_tv)
   );

   // top of book and mid, straight from cell 0 of each row
   always_comb begin
      sel_stat  = side_ff ? ask_stat : bid_stat;
      sel_hvol  = side_ff ? ask_hvol : bid_hvol;
      sel_count = side_ff ? ask_count : bid_count;
      bp64  = bid_stat.empty ? 64'd0 : 64'(bid_tp[0]);
      ap64  = ask_stat.empty ? 64'd0 : 64'(ask_tp[0]);
      mid64 = (bp64 != 64'd0 && ap64 != 64'd0) ? bp64 + ap64 : 64'd0;
      lp64  = 64'(sp_ff[0]);
      sum   = $signed({2'b00, sel_hvol}) + $signed({delta_ff[31], delta_ff});
      // snapshot depth: zero acts as one, capped by the limit and by the side's count
      n_snap = (want_ff == 5'd0) ? 1 : int'(want_ff);
      if (n_snap > MAX_SNAPSHOT) n_snap = MAX_SNAPSHOT;
      if (n_snap > int'(sel_count)) n_snap = int'(sel_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load | (rsp_valid_ff & ~rsp_chan.ready);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  side_ff   <= req_chan.side;
                  price_ff  <= req_price64[PRICE_BITS-1:0];
                  delta_ff  <= req_chan.volume_delta;
                  want_ff   <= req_chan.snapshot_levels;
                  status_ff <= 1'b0;
                  case (req_chan.req_type)
                     REQ_UPDATE:   state_ff <= ST_CMP;
                     REQ_SNAPSHOT: state_ff <= ST_SNAP_LD;
                     default:      state_ff <= ST_RESP;
                  endcase
               end
            end
            ST_CMP: state_ff <= ST_DEC;
            ST_DEC: begin
               // one matching level at most, found at the boundary cell
               act_ff <= OP_HOLD;
               if (sel_stat.hit) begin
                  if (sum <= 33'sd0) begin
                     act_ff <= OP_DEL;
                  end else begin
                     act_ff    <= OP_SET;
                     newvol_ff <= (sum > $signed({2'b00, VOL_MAX})) ? VOL_MAX : sum[30:0];
                  end
               end else if (delta_ff > 32'sd0) begin
                  if (sel_stat.full) begin
                     status_ff <= 1'b1;
                  end else begin
                     act_ff    <= OP_INS;
                     newvol_ff <= delta_ff[30:0];
                  end
               end
               state_ff <= ST_APPLY;
            end
            ST_APPLY: state_ff <= ST_RESP;
            ST_SNAP_LD: begin
               for (int k = 0; k < SNAP_D; k++) begin
                  sp_ff[k] <= side_ff ? ask_tp[k] : bid_tp[k];
                  sv_ff[k] <= side_ff ? ask_tv[k] : bid_tv[k];
               end
               rem_ff   <= RW'(n_snap);
               state_ff <= sel_stat.empty ? ST_RESP : ST_SNAP;
            end
            ST_SNAP: begin
               if (slot_free) begin
                  rsp_status_ff <= 1'b0;
                  rsp_bbp_ff    <= bp64[31:0];
                  rsp_bbv_ff    <= bid_stat.empty ? 31'd0 : bid_tv[0];
                  rsp_bap_ff    <= ap64[31:0];
                  rsp_bav_ff    <= ask_stat.empty ? 31'd0 : ask_tv[0];
                  rsp_mid_ff    <= mid64[32:0];
                  rsp_lp_ff     <= lp64[31:0];
                  rsp_lv_ff     <= sv_ff[0];
                  rsp_lvalid_ff <= 1'b1;
                  rsp_last_ff   <= (rem_ff == RW'(1));
                  for (int k = 0; k < SNAP_D - 1; k++) begin
                     sp_ff[k] <= sp_ff[k+1];
                     sv_ff[k] <= sv_ff[k+1];
                  end
                  rem_ff <= rem_ff - 1'b1;
                  if (rem_ff == RW'(1)) state_ff <= ST_IDLE;
               end
            end
            ST_RESP: begin
               if (slot_free) begin
                  rsp_status_ff <= status_ff;
                  rsp_bbp_ff    <= bp64[31:0];
                  rsp_bbv_ff    <= bid_stat.empty ? 31'd0 : bid_tv[0];
                  rsp_bap_ff    <= ap64[31:0];
                  rsp_bav_ff    <= ask_stat.empty ? 31'd0 : ask_tv[0];
                  rsp_mid_ff    <= mid64[32:0];
                  rsp_lp_ff     <= 32'd0;
                  rsp_lv_ff     <= 31'd0;
                  rsp_lvalid_ff <= 1'b0;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.best_bid_price  = rsp_bbp_ff;
   assign rsp_chan.best_bid_volume = rsp_bbv_ff;
   assign rsp_chan.best_ask_price  = rsp_bap_ff;
   assign rsp_chan.best_ask_volume = rsp_bav_ff;
   assign rsp_chan.mid_half_ticks  = rsp_mid_ff;
   assign rsp_chan.level_price     = rsp_lp_ff;
   assign rsp_chan.level_volume    = rsp_lv_ff;
   assign rsp_chan.level_valid     = rsp_lvalid_ff;
   assign rsp_chan.last            = rsp_last_ff;

   // counts stay within the row
   `PLOB_ASSERT(a_count_range, clock, reset, (bid_count <= CW'(LEVELS_PER_SIDE)) && (ask_count <= CW'(LEVELS_PER_SIDE)), "level count beyond row length")
   // a full-side drop is only ever reported on a single update result
   `PLOB_ASSERT(a_status_update, clock, reset, (rsp_chan.valid && rsp_chan.status) |-> (!rsp_chan.level_valid && rsp_chan.last), "drop flag on a snapshot result")
   // one transaction in flight: acceptance closes the input
   `PLOB_ASSERT(a_one_in_flight, clock, reset, (req_chan.valid && req_chan.ready) |=> !req_chan.ready, "input taken twice in a row")
endmodule
`default_nettype wire
